@@ sv/prw_pkg.sv @@
// packet ring writer: shared types and codes
// word layouts of both channels and the command passed from front to back
// no dependencies
package prw_pkg;

  typedef struct packed {
    logic        operation;
    logic [11:0] header_length;
    logic [11:0] data_length;
    logic [11:0] host_read_index;
    logic        host_interrupt_mask;
    logic [7:0]  data_byte;
  } prw_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] write_index;
    logic        signal_host;
  } prw_out_t;

  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  localparam logic [1:0] ST_COMMIT    = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_NO_PACKET = 2'd2;
  localparam logic [1:0] ST_OPEN      = 2'd3;

  localparam int MIN_RING = 64;
  localparam int MAX_RING = 4096;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_BYTE  = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [12:0] total;
    logic [13:0] aligned;
    logic [2:0]  pad;
    logic [11:0] read_index;
    logic        mask;
    logic [7:0]  data_byte;
  } prw_cmd_t;

endpackage

@@ sv/packet_ring_writer_core.sv @@
// Packet ring writer. A start word checks ring space for the announced packet and opens it;
// byte words are stored one a cycle into the ring while the result queue has room; after
// the last byte the block writes zero padding to the 8-byte boundary and an 8-byte trailer
// carrying the old write index, one ring byte a cycle, then commits and posts a result. A
// start word holds the back end through the pop, two remainder passes of 6 steps each and a
// done flag (write index and host read index modulo the ring size) and the space check. A
// byte word is stored directly, or after a remainder pass when the ring size was changed
// while a packet was open and the cursor has to be reduced first. Pad and trailer follow the
// last byte through the single ring write port. Words in and results out pass 2-deep queues.
// depends on prw_pkg, prw_front, prw_back, prw_fifo
module packet_ring_writer_core #(
  parameter int RING_BYTES = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  prw_pkg::prw_in_t  in_word,
  output logic              empty,
  input  logic              pop,
  output prw_pkg::prw_out_t out_word,
  input  logic              cfg_we,
  input  logic [12:0]       cfg_wdata
);

  import prw_pkg::*;

  localparam int RB8 = RING_BYTES - (RING_BYTES % 8);
  localparam int LIM = (RB8 > MAX_RING) ? MAX_RING : RB8;

  logic [12:0] size_r;
  logic [12:0] size_nxt;
  logic        cmd_pop;
  logic        cmd_empty;
  prw_cmd_t    cmd_word;
  logic        res_full;
  logic        res_push;
  prw_out_t    res_word;

  always_comb begin
    size_nxt = {cfg_wdata[12:3], 3'd0};
    if (size_nxt > 13'(LIM)) begin
      size_nxt = 13'(LIM);
    end
    if (size_nxt < 13'(MIN_RING)) begin
      size_nxt = 13'(MIN_RING);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 13'(LIM);
    end else if (cfg_we) begin
      size_r <= size_nxt;
    end
  end

  prw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_word   (in_word),
    .cmd_pop   (cmd_pop),
    .cmd_empty (cmd_empty),
    .cmd_word  (cmd_word)
  );

  prw_back #(
    .RING_BYTES (RING_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .size      (size_r),
    .cmd_empty (cmd_empty),
    .cmd_word  (cmd_word),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_word  (res_word)
  );

  prw_fifo #(
    .W     ($bits(prw_out_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_word),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_word),
    .empty (empty)
  );

endmodule

@@ sv/prw_fifo.sv @@
// packet ring writer: small word queue, depth a power of two
// used between front and back and on the result side
// no dependencies
module prw_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push;
  logic          do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ sv/prw_front.sv @@
// packet ring writer front: accepts input words and turns them into commands
// depends on prw_pkg and prw_fifo
module prw_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  prw_pkg::prw_in_t  in_word,
  input  logic              cmd_pop,
  output logic              cmd_empty,
  output prw_pkg::prw_cmd_t cmd_word
);

  import prw_pkg::*;

  prw_cmd_t    cmd;
  logic [12:0] total;
  logic [13:0] aligned;

  assign total   = 13'(in_word.header_length) + 13'(in_word.data_length);
  assign aligned = (14'(total) + 14'd7) & ~14'd7;

  always_comb begin
    cmd.kind       = (in_word.operation == OP_BYTE) ? CMD_BYTE : CMD_START;
    cmd.total      = total;
    cmd.aligned    = aligned;
    cmd.pad        = 3'(aligned - 14'(total));
    cmd.read_index = in_word.host_read_index;
    cmd.mask       = in_word.host_interrupt_mask;
    cmd.data_byte  = in_word.data_byte;
  end

  prw_fifo #(
    .W     ($bits(prw_cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (cmd),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_word),
    .empty (cmd_empty)
  );

endmodule

@@ sv/prw_rem.sv @@
// packet ring writer: iterative remainder of a ring index by the ring size
// restoring steps, one quotient bit a cycle; no dependencies
module prw_rem (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [11:0] dividend,
  input  logic [12:0] divisor,
  output logic        done,
  output logic [11:0] remainder
);

  localparam logic [2:0] LAST_STEP = 3'd5;

  logic        busy_r;
  logic        done_r;
  logic [2:0]  step_r;
  logic [11:0] rem_r;
  logic [17:0] shifted;
  logic        ge;

  assign shifted   = 18'(divisor) << step_r;
  assign ge        = (18'(rem_r) >= shifted);
  assign done      = done_r;
  assign remainder = rem_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= dividend;
      step_r <= LAST_STEP;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - shifted[11:0];
      end
      step_r <= step_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && !start && (step_r == 3'd0);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == 3'd0) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule

@@ sv/prw_back.sv @@
// packet ring writer back: space check, byte stores, padding and trailer, commit
// depends on prw_pkg and prw_rem; holds the ring memory
module prw_back #(
  parameter int RING_BYTES = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [12:0]       size,
  input  logic              cmd_empty,
  input  prw_pkg::prw_cmd_t cmd_word,
  output logic              cmd_pop,
  input  logic              res_full,
  output logic              res_push,
  output prw_pkg::prw_out_t res_word
);

  import prw_pkg::*;

  localparam int RB8 = RING_BYTES - (RING_BYTES % 8);
  localparam int LIM = (RB8 > MAX_RING) ? MAX_RING : RB8;
  localparam int AW  = $clog2(LIM);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WI    = 6'b000010,
    S_RI    = 6'b000100,
    S_CHECK = 6'b001000,
    S_RCUR  = 6'b010000,
    S_TAIL  = 6'b100000
  } state_t;

  logic [7:0] ring_mem [LIM];

  state_t      state_r, state_nxt;
  logic        open_r, open_nxt;
  logic        mask_r, mask_nxt;
  logic [11:0] commit_r, commit_nxt;
  logic [11:0] cursor_r, cursor_nxt;
  logic [12:0] left_r, left_nxt;
  logic [2:0]  pad_r, pad_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [11:0] wi_r, wi_nxt;
  logic [11:0] ri_r, ri_nxt;
  prw_cmd_t    cmd_r, cmd_nxt;

  logic        rem_start;
  logic [11:0] rem_x;
  logic        rem_done;
  logic [11:0] rem_res;

  logic        mem_we;
  logic [11:0] mem_idx;
  logic [7:0]  mem_wdata;

  logic [11:0] put_idx;
  logic [12:0] put_inc;
  logic [11:0] put_next;
  logic [12:0] used;
  logic [12:0] avail;
  logic [3:0]  tail_k;

  prw_rem u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rem_start),
    .dividend  (rem_x),
    .divisor   (size),
    .done      (rem_done),
    .remainder (rem_res)
  );

  assign put_idx  = (state_r == S_RCUR) ? rem_res : cursor_r;
  assign put_inc  = 13'(put_idx) + 13'd1;
  assign put_next = (put_inc == size) ? 12'd0 : put_inc[11:0];
  assign used     = (wi_r >= ri_r) ? (13'(wi_r) - 13'(ri_r))
                                   : (13'(wi_r) + size - 13'(ri_r));
  assign avail    = size - used;
  assign tail_k   = step_r - 4'(pad_r);

  always_comb begin
    state_nxt  = state_r;
    open_nxt   = open_r;
    mask_nxt   = mask_r;
    commit_nxt = commit_r;
    cursor_nxt = cursor_r;
    left_nxt   = left_r;
    pad_nxt    = pad_r;
    step_nxt   = step_r;
    wi_nxt     = wi_r;
    ri_nxt     = ri_r;
    cmd_nxt    = cmd_r;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    res_word   = '0;
    rem_start  = 1'b0;
    rem_x      = commit_r;
    mem_we     = 1'b0;
    mem_idx    = put_idx;
    mem_wdata  = cmd_r.data_byte;

    case (state_r)
      S_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd_word;
          case (cmd_word.kind)
            CMD_START: begin
              if (open_r) begin
                res_push             = 1'b1;
                res_word.status      = ST_OPEN;
                res_word.write_index = commit_r;
              end else begin
                rem_start = 1'b1;
                rem_x     = commit_r;
                state_nxt = S_WI;
              end
            end
            CMD_BYTE: begin
              if (!open_r) begin
                res_push             = 1'b1;
                res_word.status      = ST_NO_PACKET;
                res_word.write_index = commit_r;
              end else if (13'(cursor_r) >= size) begin
                rem_start = 1'b1;
                rem_x     = cursor_r;
                state_nxt = S_RCUR;
              end else begin
                mem_we     = 1'b1;
                mem_wdata  = cmd_word.data_byte;
                cursor_nxt = put_next;
                left_nxt   = left_r - 13'd1;
                if (left_r == 13'd1) begin
                  step_nxt  = 4'd0;
                  state_nxt = S_TAIL;
                end
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_WI: begin
        if (rem_done) begin
          wi_nxt    = rem_res;
          rem_start = 1'b1;
          rem_x     = cmd_r.read_index;
          state_nxt = S_RI;
        end
      end
      S_RI: begin
        if (rem_done) begin
          ri_nxt    = rem_res;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        commit_nxt = wi_r;
        if (14'(avail) <= cmd_r.aligned) begin
          res_push             = 1'b1;
          res_word.status      = ST_NO_SPACE;
          res_word.write_index = wi_r;
          state_nxt            = S_IDLE;
        end else begin
          cursor_nxt = wi_r;
          left_nxt   = cmd_r.total;
          pad_nxt    = cmd_r.pad;
          mask_nxt   = cmd_r.mask;
          open_nxt   = 1'b1;
          step_nxt   = 4'd0;
          state_nxt  = (cmd_r.total == 13'd0) ? S_TAIL : S_IDLE;
        end
      end
      S_RCUR: begin
        if (rem_done) begin
          mem_we     = 1'b1;
          cursor_nxt = put_next;
          left_nxt   = left_r - 13'd1;
          step_nxt   = 4'd0;
          state_nxt  = (left_r == 13'd1) ? S_TAIL : S_IDLE;
        end
      end
      S_TAIL: begin
        mem_we     = 1'b1;
        cursor_nxt = put_next;
        case (tail_k)
          4'd4:    mem_wdata = commit_r[7:0];
          4'd5:    mem_wdata = {4'd0, commit_r[11:8]};
          default: mem_wdata = 8'd0;
        endcase
        if (step_r == 4'(pad_r) + 4'd7) begin
          commit_nxt           = put_next;
          res_push             = 1'b1;
          res_word.status      = ST_COMMIT;
          res_word.write_index = put_next;
          res_word.signal_host = !mask_r;
          open_nxt             = 1'b0;
          left_nxt             = 13'd0;
          pad_nxt              = 3'd0;
          state_nxt            = S_IDLE;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_idx[AW-1:0]] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    wi_r   <= wi_nxt;
    ri_r   <= ri_nxt;
    cmd_r  <= cmd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      open_r   <= 1'b0;
      mask_r   <= 1'b0;
      commit_r <= '0;
      cursor_r <= '0;
      left_r   <= '0;
      pad_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      open_r   <= open_nxt;
      mask_r   <= mask_nxt;
      commit_r <= commit_nxt;
      cursor_r <= cursor_nxt;
      left_r   <= left_nxt;
      pad_r    <= pad_nxt;
    end
  end

endmodule

@@ tb/prw_checker.sv @@
`timescale 1ns / 100ps
// packet ring writer checker: watches the word, result and config ports of the block,
// predicts every result from the accepted words and compares them in order
// depends on prw_pkg
module prw_checker #(
  parameter int RING_BYTES = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic              full,
  input  prw_pkg::prw_in_t  in_word,
  input  logic              empty,
  input  logic              pop,
  input  prw_pkg::prw_out_t out_word,
  input  logic              cfg_we,
  input  logic [12:0]       cfg_wdata,
  output int                fail_count,
  output int                pending_count,
  output logic [11:0]       commit_view
);
  import prw_pkg::*;

  logic [12:0] ring_cfg;
  logic [11:0] commit_idx;
  int          cursor;
  int          bytes_left;
  int          pad;
  logic        pkt_open;
  logic        mask_q;
  int          shown;
  prw_out_t    pending_results[$];

  function automatic int ring_span(input logic [12:0] cfg);
    int lim;
    int s;
    lim = RING_BYTES & ~7;
    if (lim > MAX_RING) lim = MAX_RING;
    s = int'(cfg) & ~7;
    if (s > lim) s = lim;
    if (s < MIN_RING) s = MIN_RING;
    if (s > RING_BYTES) s = RING_BYTES;
    return s;
  endfunction

  task automatic close_packet(input int s);
    prw_out_t r;
    cursor = (cursor % s + pad + 8) % s;
    commit_idx = cursor[11:0];
    pkt_open = 1'b0;
    bytes_left = 0;
    pad = 0;
    r.status = ST_COMMIT;
    r.write_index = commit_idx;
    r.signal_host = !mask_q;
    pending_results.push_back(r);
  endtask

  task automatic push_status(input logic [1:0] st);
    prw_out_t r;
    r.status = st;
    r.write_index = commit_idx;
    r.signal_host = 1'b0;
    pending_results.push_back(r);
  endtask

  task automatic predict_ring_word(input prw_in_t w);
    int s;
    int total;
    int aligned;
    int wi;
    int ri;
    int used;
    int avail;
    s = ring_span(ring_cfg);
    if (w.operation == OP_START) begin
      if (pkt_open) begin
        push_status(ST_OPEN);
      end else begin
        total = int'(w.header_length) + int'(w.data_length);
        aligned = (total + 7) & ~7;
        wi = int'(commit_idx) % s;
        ri = int'(w.host_read_index) % s;
        used = (wi >= ri) ? (wi - ri) : (wi + s - ri);
        avail = s - used;
        commit_idx = wi[11:0];
        if (avail <= aligned) begin
          push_status(ST_NO_SPACE);
        end else begin
          cursor = wi;
          bytes_left = total;
          pad = aligned - total;
          mask_q = w.host_interrupt_mask;
          pkt_open = 1'b1;
          if (total == 0) close_packet(s);
        end
      end
    end else if (!pkt_open) begin
      push_status(ST_NO_PACKET);
    end else begin
      cursor = (cursor % s + 1) % s;
      if (bytes_left > 0) bytes_left--;
      if (bytes_left == 0) close_packet(s);
    end
  endtask

  always @(posedge clk) begin
    prw_out_t want;
    if (!rst_n) begin
      ring_cfg = 13'd4096;
      commit_idx = '0;
      cursor = 0;
      bytes_left = 0;
      pad = 0;
      pkt_open = 1'b0;
      mask_q = 1'b0;
      shown = 0;
      fail_count = 0;
      pending_results.delete();
      pending_count <= 0;
      commit_view <= '0;
    end else begin
      if (cfg_we) ring_cfg = cfg_wdata;
      if (push && !full) predict_ring_word(in_word);
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          if (shown < 10) begin
            shown++;
            $display("unexpected result: status %0d index %0d signal %0d",
                     out_word.status, out_word.write_index, out_word.signal_host);
          end
        end else begin
          want = pending_results.pop_front();
          if (out_word.status !== want.status || out_word.write_index !== want.write_index ||
              out_word.signal_host !== want.signal_host) begin
            fail_count++;
            if (shown < 10) begin
              shown++;
              $display("mismatch: expected status %0d index %0d signal %0d, got %0d %0d %0d",
                       want.status, want.write_index, want.signal_host,
                       out_word.status, out_word.write_index, out_word.signal_host);
            end
          end
        end
      end
      pending_count <= pending_results.size();
      commit_view <= commit_idx;
    end
  end

endmodule

@@ tb/tb_packet_ring_writer_core.sv @@
`timescale 1ns / 100ps
// testbench top for packet_ring_writer_core: clock, reset, packet stimulus, random stalls
// on both queues and ring size changes; the verdict comes from prw_checker
// depends on prw_pkg, packet_ring_writer_core, prw_checker
module tb_packet_ring_writer_core;
  import prw_pkg::*;

  localparam int RING_BYTES  = 4096;
  localparam int DRAIN_WAIT  = 64;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_WORDS = 100;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  prw_in_t     in_word;
  logic        empty;
  logic        pop;
  prw_out_t    out_word;
  logic        cfg_we;
  logic [12:0] cfg_wdata;

  int          fail_count;
  int          pending_count;
  logic [11:0] commit_view;
  int          cycle_count;
  int          words_sent;
  logic        in_fast;
  logic        out_fast;
  logic [12:0] cur_cfg;

  packet_ring_writer_core #(.RING_BYTES(RING_BYTES)) uut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_word(in_word),
    .empty(empty), .pop(pop), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  prw_checker #(.RING_BYTES(RING_BYTES)) chk (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_word(in_word),
    .empty(empty), .pop(pop), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending_count(pending_count), .commit_view(commit_view)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic prw_in_t rand_word();
    prw_in_t w;
    w.operation = 1'($urandom_range(0, 1));
    w.header_length = 12'($urandom);
    w.data_length = 12'($urandom);
    w.host_read_index = 12'($urandom);
    w.host_interrupt_mask = 1'($urandom_range(0, 1));
    w.data_byte = 8'($urandom);
    return w;
  endfunction

  function automatic prw_in_t start_word(input int h, input int d, input logic [11:0] rd,
                                         input logic m);
    prw_in_t w;
    w = rand_word();
    w.operation = OP_START;
    w.header_length = h[11:0];
    w.data_length = d[11:0];
    w.host_read_index = rd;
    w.host_interrupt_mask = m;
    return w;
  endfunction

  function automatic prw_in_t byte_word(input logic [7:0] b);
    prw_in_t w;
    w = rand_word();
    w.operation = OP_BYTE;
    w.data_byte = b;
    return w;
  endfunction

  task automatic send_word(input prw_in_t w);
    int gap;
    gap = in_fast ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (full);
    words_sent++;
  endtask

  task automatic send_packet(input int h, input int d, input logic [11:0] rd, input logic m,
                             input int nbytes);
    send_word(start_word(h, d, rd, m));
    for (int i = 0; i < nbytes; i++) send_word(byte_word(8'($urandom)));
  endtask

  // sender holds off until every expected result is out and the block has gone quiet
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_ring_size(input logic [12:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    cur_cfg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int nwords, input bit hold_midway);
    int target;
    int r;
    int t;
    int h;
    int max_len;
    logic [11:0] rd;
    target = words_sent + nwords;
    in_fast = ($urandom_range(0, 3) == 0);
    out_fast = ($urandom_range(0, 3) == 0);
    max_len = (cur_cfg >= 13'd512 && cur_cfg <= 13'd4096) ? 300 : 40;
    while (words_sent < target) begin
      if (hold_midway && words_sent >= target - nwords / 2) begin
        hold_midway = 1'b0;
        wait_idle();
      end
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 9) < 7) rd = commit_view - 12'($urandom_range(0, 16));
      else rd = 12'($urandom);
      if ($urandom_range(0, 19) == 0) t = $urandom_range(0, max_len);
      else t = $urandom_range(0, 24);
      h = $urandom_range(0, t);
      if (r < 75) begin
        send_packet(h, t - h, rd, 1'($urandom_range(0, 1)), t);
      end else if (r < 87) begin
        send_packet(h, t - h, rd, 1'($urandom_range(0, 1)),
                    (t == 0) ? 0 : $urandom_range(0, t - 1));
      end else begin
        send_word(rand_word());
      end
    end
  endtask

  initial begin
    pop <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      int gap;
      gap = out_fast ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  initial begin
    logic [12:0] sizes[9];
    rst_n <= 1'b0;
    push <= 1'b0;
    in_word <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    cycle_count <= 0;
    words_sent = 0;
    in_fast = 1'b0;
    out_fast = 1'b0;
    cur_cfg = 13'd4096;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // byte with no open packet
    send_word(byte_word(8'hff));
    send_word(byte_word(8'h00));
    // empty packets, signal on and off
    send_word(start_word(0, 0, 12'd0, 1'b0));
    send_word(start_word(0, 0, commit_view, 1'b1));
    // longest lengths never fit
    send_word(start_word(4095, 4095, 12'd0, 1'b0));
    send_packet(1, 0, commit_view, 1'b0, 1);
    send_packet(3, 5, commit_view, 1'b1, 8);
    // start while a packet is open, then finish the open one
    send_packet(2, 2, commit_view, 1'b0, 1);
    send_word(start_word(4095, 0, 12'd4095, 1'b1));
    for (int i = 0; i < 3; i++) send_word(byte_word(8'($urandom)));
    // free space exactly the padded length is rejected, one more byte fits
    wait_idle();
    send_word(start_word(0, 1, commit_view + 12'd8, 1'b0));
    send_packet(1, 0, commit_view + 12'd9, 1'b0, 1);

    sizes[0] = 13'd4096;
    sizes[1] = 13'd64;
    sizes[2] = 13'd8191;
    sizes[3] = 13'd0;
    sizes[4] = 13'd100;
    sizes[5] = 13'($urandom_range(8, 512) * 8);
    sizes[6] = 13'($urandom);
    sizes[7] = 13'd72;
    sizes[8] = 13'd4095;
    for (int p = 0; p < 9; p++) begin
      write_ring_size(sizes[p]);
      random_phase(PHASE_WORDS, p == 2);
    end

    wait_idle();
    if (fail_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
